// ===== rtl/gaussian_blur_3x3_macros.svh =====
// Assertion macros for the 3x3 blur block.
`ifndef GAUSSIAN_BLUR_3X3_MACROS_SVH
`define GAUSSIAN_BLUR_3X3_MACROS_SVH

// Check a property on every clock edge outside reset.
`define GB3_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition leads to a consequence on the next clock edge.
`define GB3_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/gb3_pkg.sv =====
// Shared types and constants of the 3x3 blur block.
`timescale 1ns / 1ps

package gb3_pkg;

  localparam int NUM_CH      = 4;
  localparam int CHAN_W      = 8;
  localparam int PIX_W       = NUM_CH * CHAN_W;
  localparam int COLSUM_W    = CHAN_W + 2;
  localparam int SUM_W       = CHAN_W + 4;
  localparam int COORD_W     = 11;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 12;
  localparam int CH_CNT_W    = 3;
  localparam int WIDTH_RST   = 640;
  localparam int HEIGHT_RST  = 480;
  localparam logic [NUM_CH-1:0] CH_MASK_RST = 4'b0111;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH,
    CFG_HEIGHT,
    CFG_CHANNELS
  } cfg_idx_t;

  typedef struct packed {
    logic shift;
    logic load;
  } gb3_lane_ctl_t;

endpackage

// ===== rtl/gb3_if.sv =====
// Stream and configuration channel interfaces of the 3x3 blur block.
`timescale 1ns / 1ps

interface gb3_in_if;
  logic                      valid;
  logic                      ready;
  logic [gb3_pkg::CHAN_W-1:0] chan0_in;
  logic [gb3_pkg::CHAN_W-1:0] chan1_in;
  logic [gb3_pkg::CHAN_W-1:0] chan2_in;
  logic [gb3_pkg::CHAN_W-1:0] chan3_in;

  modport source (output valid, chan0_in, chan1_in, chan2_in, chan3_in, input ready);
  modport sink (input valid, chan0_in, chan1_in, chan2_in, chan3_in, output ready);
endinterface

interface gb3_out_if;
  logic                        valid;
  logic                        ready;
  logic [gb3_pkg::COORD_W-1:0] out_col;
  logic [gb3_pkg::COORD_W-1:0] out_row;
  logic [gb3_pkg::CHAN_W-1:0]  chan0_out;
  logic [gb3_pkg::CHAN_W-1:0]  chan1_out;
  logic [gb3_pkg::CHAN_W-1:0]  chan2_out;
  logic [gb3_pkg::CHAN_W-1:0]  chan3_out;
  logic                        last_of_run;

  modport source (output valid, out_col, out_row, chan0_out, chan1_out, chan2_out,
                  chan3_out, last_of_run, input ready);
  modport sink (input valid, out_col, out_row, chan0_out, chan1_out, chan2_out,
                chan3_out, last_of_run, output ready);
endinterface

interface gb3_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [gb3_pkg::CFG_IDX_W-1:0]  index;
  logic [gb3_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/gaussian_blur_3x3.sv =====
// Top level of the streaming 3x3 binomial blur.
`timescale 1ns / 1ps
`include "gaussian_blur_3x3_macros.svh"

// Streaming 3x3 binomial blur (1-2-1 by 1-2-1, divided by 16, truncated) over raster-order
// pixels of up to four 8-bit channels, one channel per lane. The block accepts one pixel
// per clock while the result port is not stalled; each pixel yields zero, one or two
// results, and the result port moves one per clock, so a border pixel that also completes
// an interior result holds the input back. Results leave through stage 1 and stage 2.
// Two line RAMs of MAX_WIDTH x 32 bits, each with one read and one write per cycle, hold
// the two previous rows; they need no clearing pass after reset. Configuration writes
// are taken at any time with cfg ready held high, and belong between frames.
module gaussian_blur_3x3 #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic           clk,
  input  logic           rst_n,
  gb3_in_if.sink         in_pix,
  gb3_out_if.source      out_pix,
  gb3_cfg_if.sink        cfg_wr
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int W_LAST_RST =
    ((gb3_pkg::WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : gb3_pkg::WIDTH_RST) - 1;
  localparam int H_LAST_RST =
    ((gb3_pkg::HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : gb3_pkg::HEIGHT_RST) - 1;

  // configuration
  logic [XW-1:0]              w_last_r, w_last_nxt;
  logic [YW-1:0]              h_last_r, h_last_nxt;
  logic [gb3_pkg::NUM_CH-1:0] ch_mask_r, ch_mask_nxt;

  // position counters
  logic [XW-1:0] x_r, x_nxt;
  logic [YW-1:0] y_r, y_nxt;

  // stage 1: line RAM read
  logic                      s1_v_r, s1_v_nxt;
  logic [XW-1:0]             s1_x_r, s1_x_nxt;
  logic [YW-1:0]             s1_y_r, s1_y_nxt;
  logic                      s1_int_r, s1_int_nxt;
  logic                      s1_bord_r, s1_bord_nxt;
  logic [gb3_pkg::PIX_W-1:0] s1_cur_r, s1_cur_nxt;
  logic                      s1_fwd_r, s1_fwd_nxt;
  logic [gb3_pkg::PIX_W-1:0] s1_fwd_up_r, s1_fwd_up_nxt;
  logic [gb3_pkg::PIX_W-1:0] s1_fwd_mid_r, s1_fwd_mid_nxt;

  // stage 2: result output
  logic          s2_v_r, s2_v_nxt;
  logic [XW-1:0] s2_x_r, s2_x_nxt;
  logic [YW-1:0] s2_y_r, s2_y_nxt;
  logic          s2_int_r, s2_int_nxt;
  logic          s2_bord_r, s2_bord_nxt;

  logic                      in_xfer;
  logic                      out_xfer;
  logic                      s1_has_out;
  logic                      s1_adv;
  logic                      s2_last;
  logic                      s2_free;
  logic [gb3_pkg::PIX_W-1:0] cur_word;
  logic [gb3_pkg::PIX_W-1:0] up_q;
  logic [gb3_pkg::PIX_W-1:0] mid_q;
  logic [gb3_pkg::PIX_W-1:0] up_eff;
  logic [gb3_pkg::PIX_W-1:0] mid_eff;
  logic [gb3_pkg::CHAN_W-1:0] in_byte  [gb3_pkg::NUM_CH];
  logic [gb3_pkg::CHAN_W-1:0] lane_res [gb3_pkg::NUM_CH];
  gb3_pkg::gb3_lane_ctl_t     lane_ctl;

  assign cfg_wr.ready = 1'b1;

  always_comb begin
    w_last_nxt  = w_last_r;
    h_last_nxt  = h_last_r;
    ch_mask_nxt = ch_mask_r;
    if (cfg_wr.valid) begin
      case (cfg_wr.index)
        gb3_pkg::CFG_WIDTH: begin
          if (cfg_wr.data == '0) begin
            w_last_nxt = '0;
          end else if (32'(cfg_wr.data) > MAX_WIDTH) begin
            w_last_nxt = XW'(MAX_WIDTH - 1);
          end else begin
            w_last_nxt = XW'(32'(cfg_wr.data) - 1);
          end
        end
        gb3_pkg::CFG_HEIGHT: begin
          if (cfg_wr.data == '0) begin
            h_last_nxt = '0;
          end else if (32'(cfg_wr.data) > MAX_HEIGHT) begin
            h_last_nxt = YW'(MAX_HEIGHT - 1);
          end else begin
            h_last_nxt = YW'(32'(cfg_wr.data) - 1);
          end
        end
        gb3_pkg::CFG_CHANNELS: begin
          for (int c = 0; c < gb3_pkg::NUM_CH; c++) begin
            ch_mask_nxt[c] = cfg_wr.data[gb3_pkg::CH_CNT_W-1:0] > gb3_pkg::CH_CNT_W'(c);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign in_byte[0] = in_pix.chan0_in;
  assign in_byte[1] = in_pix.chan1_in;
  assign in_byte[2] = in_pix.chan2_in;
  assign in_byte[3] = in_pix.chan3_in;

  always_comb begin
    for (int c = 0; c < gb3_pkg::NUM_CH; c++) begin
      cur_word[c*gb3_pkg::CHAN_W +: gb3_pkg::CHAN_W] = ch_mask_r[c] ? in_byte[c] : '0;
    end
  end

  assign out_xfer   = out_pix.valid && out_pix.ready;
  assign s2_last    = !(s2_int_r && s2_bord_r);
  assign s2_free    = !s2_v_r || (out_xfer && s2_last);
  assign s1_has_out = s1_int_r || s1_bord_r;
  assign s1_adv     = s1_v_r && (!s1_has_out || s2_free);
  assign in_pix.ready = !s1_v_r || s1_adv;
  assign in_xfer    = in_pix.valid && in_pix.ready;

  assign up_eff  = s1_fwd_r ? s1_fwd_up_r : up_q;
  assign mid_eff = s1_fwd_r ? s1_fwd_mid_r : mid_q;

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    if (in_xfer) begin
      if (x_r >= w_last_r) begin
        x_nxt = '0;
        y_nxt = (y_r >= h_last_r) ? '0 : y_r + YW'(1);
      end else begin
        x_nxt = x_r + XW'(1);
      end
    end
  end

  always_comb begin
    s1_v_nxt       = s1_v_r;
    s1_x_nxt       = s1_x_r;
    s1_y_nxt       = s1_y_r;
    s1_int_nxt     = s1_int_r;
    s1_bord_nxt    = s1_bord_r;
    s1_cur_nxt     = s1_cur_r;
    s1_fwd_nxt     = s1_fwd_r;
    s1_fwd_up_nxt  = s1_fwd_up_r;
    s1_fwd_mid_nxt = s1_fwd_mid_r;
    if (in_xfer) begin
      s1_v_nxt       = 1'b1;
      s1_x_nxt       = x_r;
      s1_y_nxt       = y_r;
      s1_int_nxt     = (x_r >= XW'(2)) && (y_r >= YW'(2));
      s1_bord_nxt    = (x_r == '0) || (y_r == '0) || (x_r >= w_last_r) || (y_r >= h_last_r);
      s1_cur_nxt     = cur_word;
      // read and write of the same entry at one edge: forward the data being written
      s1_fwd_nxt     = s1_adv && (s1_x_r == x_r);
      s1_fwd_up_nxt  = mid_eff;
      s1_fwd_mid_nxt = s1_cur_r;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
  end

  always_comb begin
    s2_v_nxt    = s2_v_r;
    s2_x_nxt    = s2_x_r;
    s2_y_nxt    = s2_y_r;
    s2_int_nxt  = s2_int_r;
    s2_bord_nxt = s2_bord_r;
    if (s1_adv && s1_has_out) begin
      s2_v_nxt    = 1'b1;
      s2_x_nxt    = s1_x_r;
      s2_y_nxt    = s1_y_r;
      s2_int_nxt  = s1_int_r;
      s2_bord_nxt = s1_bord_r;
    end else if (out_xfer) begin
      if (s2_last) begin
        s2_v_nxt = 1'b0;
      end else begin
        s2_int_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r  <= XW'(W_LAST_RST);
      h_last_r  <= YW'(H_LAST_RST);
      ch_mask_r <= gb3_pkg::CH_MASK_RST;
      x_r       <= '0;
      y_r       <= '0;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
    end else begin
      w_last_r  <= w_last_nxt;
      h_last_r  <= h_last_nxt;
      ch_mask_r <= ch_mask_nxt;
      x_r       <= x_nxt;
      y_r       <= y_nxt;
      s1_v_r    <= s1_v_nxt;
      s2_v_r    <= s2_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_x_r       <= s1_x_nxt;
    s1_y_r       <= s1_y_nxt;
    s1_int_r     <= s1_int_nxt;
    s1_bord_r    <= s1_bord_nxt;
    s1_cur_r     <= s1_cur_nxt;
    s1_fwd_r     <= s1_fwd_nxt;
    s1_fwd_up_r  <= s1_fwd_up_nxt;
    s1_fwd_mid_r <= s1_fwd_mid_nxt;
    s2_x_r       <= s2_x_nxt;
    s2_y_r       <= s2_y_nxt;
    s2_int_r     <= s2_int_nxt;
    s2_bord_r    <= s2_bord_nxt;
  end

  gb3_line_ram #(
    .DEPTH (MAX_WIDTH),
    .DW    (gb3_pkg::PIX_W)
  ) u_upper_ram (
    .clk     (clk),
    .rd_en   (in_xfer),
    .rd_addr (x_r),
    .rd_data (up_q),
    .wr_en   (s1_adv),
    .wr_addr (s1_x_r),
    .wr_data (mid_eff)
  );

  gb3_line_ram #(
    .DEPTH (MAX_WIDTH),
    .DW    (gb3_pkg::PIX_W)
  ) u_middle_ram (
    .clk     (clk),
    .rd_en   (in_xfer),
    .rd_addr (x_r),
    .rd_data (mid_q),
    .wr_en   (s1_adv),
    .wr_addr (s1_x_r),
    .wr_data (s1_cur_r)
  );

  assign lane_ctl.shift = s1_adv;
  assign lane_ctl.load  = s1_adv && s1_has_out;

  for (genvar c = 0; c < gb3_pkg::NUM_CH; c++) begin : g_lane
    gb3_lane u_lane (
      .clk     (clk),
      .ctl     (lane_ctl),
      .chan_on (ch_mask_r[c]),
      .up      (up_eff[c*gb3_pkg::CHAN_W +: gb3_pkg::CHAN_W]),
      .mid     (mid_eff[c*gb3_pkg::CHAN_W +: gb3_pkg::CHAN_W]),
      .cur     (s1_cur_r[c*gb3_pkg::CHAN_W +: gb3_pkg::CHAN_W]),
      .res     (lane_res[c])
    );
  end

  always_comb begin
    out_pix.valid = s2_v_r;
    if (s2_int_r) begin
      out_pix.out_col     = gb3_pkg::COORD_W'(s2_x_r - XW'(1));
      out_pix.out_row     = gb3_pkg::COORD_W'(s2_y_r - YW'(1));
      out_pix.chan0_out   = lane_res[0];
      out_pix.chan1_out   = lane_res[1];
      out_pix.chan2_out   = lane_res[2];
      out_pix.chan3_out   = lane_res[3];
      out_pix.last_of_run = !s2_bord_r;
    end else begin
      out_pix.out_col     = gb3_pkg::COORD_W'(s2_x_r);
      out_pix.out_row     = gb3_pkg::COORD_W'(s2_y_r);
      out_pix.chan0_out   = '0;
      out_pix.chan1_out   = '0;
      out_pix.chan2_out   = '0;
      out_pix.chan3_out   = '0;
      out_pix.last_of_run = 1'b1;
    end
  end

  `GB3_ASSERT_NEXT(a_border_follows, out_xfer && s2_int_r && s2_bord_r, s2_v_r && !s2_int_r && s2_bord_r, "border result lost after interior transfer")
  `GB3_ASSERT_NEXT(a_s1_hold, s1_v_r && !s1_adv, s1_v_r && $stable(s1_x_r) && $stable(s1_y_r), "stalled stage 1 item changed")
  `GB3_ASSERT(a_s2_pending, s2_v_r |-> (s2_int_r || s2_bord_r), "output stage holds no result")
  `GB3_ASSERT(a_int_pos, (s2_v_r && s2_int_r) |-> ((s2_x_r >= XW'(2)) && (s2_y_r >= YW'(2))), "interior result at bad position")

endmodule

// ===== rtl/gb3_line_ram.sv =====
// Line store RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module gb3_line_ram #(
  parameter int DEPTH = 2048,
  parameter int DW    = 32
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DW-1:0]            rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DW-1:0]            wr_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/gb3_lane.sv =====
// One channel lane: column sum, two-column window and 1-2-1 combine.
`timescale 1ns / 1ps

module gb3_lane (
  input  logic                        clk,
  input  gb3_pkg::gb3_lane_ctl_t      ctl,
  input  logic                        chan_on,
  input  logic [gb3_pkg::CHAN_W-1:0]  up,
  input  logic [gb3_pkg::CHAN_W-1:0]  mid,
  input  logic [gb3_pkg::CHAN_W-1:0]  cur,
  output logic [gb3_pkg::CHAN_W-1:0]  res
);

  logic [gb3_pkg::COLSUM_W-1:0] col_sum;
  logic [gb3_pkg::SUM_W-1:0]    total;
  logic [gb3_pkg::COLSUM_W-1:0] wa_r;
  logic [gb3_pkg::COLSUM_W-1:0] wb_r;
  logic [gb3_pkg::CHAN_W-1:0]   res_r;

  always_comb begin
    col_sum = {2'b00, up} + {1'b0, mid, 1'b0} + {2'b00, cur};
    total   = {2'b00, wa_r} + {1'b0, wb_r, 1'b0} + {2'b00, col_sum};
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      wa_r <= wb_r;
      wb_r <= col_sum;
    end
    if (ctl.load) begin
      res_r <= chan_on ? total[gb3_pkg::SUM_W-1:4] : '0;
    end
  end

  assign res = res_r;

endmodule

// ===== tb/tb_gaussian_blur_3x3.sv =====
// Self-checking testbench for the streaming 3x3 binomial blur block.
`timescale 1ns / 1ps

module tb_gaussian_blur_3x3;

  localparam int LINE_DEPTH   = 2048;
  localparam int ROWS_MAX     = 2048;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 400;
  localparam int LONG_ROW     = 600;
  localparam int RAND_ITEMS   = 700;
  localparam int QUIET_ITEMS  = 200;
  localparam int WATCHDOG_NS  = 5_000_000;
  localparam logic [gb3_pkg::CH_CNT_W-1:0] CHANS_RST = 3'd3;
  localparam logic [gb3_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [gb3_pkg::COORD_W-1:0]                     col;
    logic [gb3_pkg::COORD_W-1:0]                     row;
    logic [gb3_pkg::NUM_CH-1:0][gb3_pkg::CHAN_W-1:0] ch;
    logic                                            last;
  } blur_res_t;

  typedef enum logic {STEP_PIXEL, STEP_CFG} step_kind_t;

  typedef struct packed {
    step_kind_t                       kind;
    logic [gb3_pkg::CFG_IDX_W-1:0]    idx;
    logic [gb3_pkg::CFG_DATA_W-1:0]   data;
    logic [gb3_pkg::PIX_W-1:0]        px;
    logic                             typed;
    blur_res_t                        res;
  } dir_step_t;

  logic clk = 1'b0;
  logic rst_n;

  gb3_in_if  in_pix_if ();
  gb3_out_if out_pix_if ();
  gb3_cfg_if cfg_if ();

  gaussian_blur_3x3 dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (in_pix_if),
    .out_pix (out_pix_if),
    .cfg_wr  (cfg_if)
  );

  always #5 clk = ~clk;

  logic [gb3_pkg::PIX_W-1:0]      line_upper [LINE_DEPTH];
  logic [gb3_pkg::PIX_W-1:0]      line_middle [LINE_DEPTH];
  logic [gb3_pkg::PIX_W-1:0]      win [6];
  int                             col_cnt;
  int                             row_cnt;
  logic [gb3_pkg::CFG_DATA_W-1:0] width_reg;
  logic [gb3_pkg::CFG_DATA_W-1:0] height_reg;
  logic [gb3_pkg::CH_CNT_W-1:0]   chans_reg;

  blur_res_t results_due [$];
  blur_res_t step_results [$];
  dir_step_t dir_steps [$];

  int  err_cnt = 0;
  int  results_seen = 0;
  int  pixels_sent = 0;
  int  frame_setups = 0;
  bit  quiet = 1'b0;
  bit  long_hold_req = 1'b0;
  bit  long_hold_done = 1'b0;
  bit  pix_offered = 1'b0;
  bit  cfg_offered = 1'b0;

  task automatic blur_predict(input logic [gb3_pkg::NUM_CH-1:0][gb3_pkg::CHAN_W-1:0] px);
    int w, h, nch, x, y, s, c;
    bit inner, border;
    logic [gb3_pkg::PIX_W-1:0] cur, up, mid;
    blur_res_t r;
    w = (width_reg == '0) ? 1 : ((width_reg > LINE_DEPTH) ? LINE_DEPTH : int'(width_reg));
    h = (height_reg == '0) ? 1 : ((height_reg > ROWS_MAX) ? ROWS_MAX : int'(height_reg));
    nch = (chans_reg > 3'd4) ? 4 : int'(chans_reg);
    x = col_cnt;
    y = row_cnt;
    cur = '0;
    step_results.delete();
    for (c = 0; c < nch; c++) cur[8*c +: 8] = px[c];
    up = line_upper[x];
    mid = line_middle[x];
    line_upper[x] = mid;
    line_middle[x] = cur;
    inner = (x >= 2) && (y >= 2);
    border = (x == 0) || (y == 0) || (x + 1 >= w) || (y + 1 >= h);
    if (inner) begin
      r = '0;
      r.col = gb3_pkg::COORD_W'(x - 1);
      r.row = gb3_pkg::COORD_W'(y - 1);
      for (c = 0; c < nch; c++) begin
        s = int'(win[0][8*c +: 8]) + 2 * int'(win[1][8*c +: 8]) + int'(win[2][8*c +: 8])
          + 2 * int'(win[3][8*c +: 8]) + 4 * int'(win[4][8*c +: 8])
          + 2 * int'(win[5][8*c +: 8])
          + int'(up[8*c +: 8]) + 2 * int'(mid[8*c +: 8]) + int'(cur[8*c +: 8]);
        r.ch[c] = gb3_pkg::CHAN_W'(s >> 4);
      end
      r.last = !border;
      step_results.push_back(r);
    end
    if (border) begin
      r = '0;
      r.col = gb3_pkg::COORD_W'(x);
      r.row = gb3_pkg::COORD_W'(y);
      r.last = 1'b1;
      step_results.push_back(r);
    end
    win[0] = win[3];
    win[1] = win[4];
    win[2] = win[5];
    win[3] = up;
    win[4] = mid;
    win[5] = cur;
    if (x + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (y + 1 >= h) ? 0 : y + 1;
    end else begin
      col_cnt = x + 1;
    end
  endtask

  task automatic send_pixel(input logic [gb3_pkg::PIX_W-1:0] px, input bit typed,
                            input blur_res_t res);
    int gap;
    if (cfg_offered) begin
      cfg_if.valid <= 1'b0;
      cfg_offered = 1'b0;
    end
    in_pix_if.valid    <= 1'b1;
    in_pix_if.chan0_in <= px[7:0];
    in_pix_if.chan1_in <= px[15:8];
    in_pix_if.chan2_in <= px[23:16];
    in_pix_if.chan3_in <= px[31:24];
    pix_offered = 1'b1;
    do @(posedge clk); while (!in_pix_if.ready);
    blur_predict(px);
    if (typed) results_due.push_back(res);
    else foreach (step_results[i]) results_due.push_back(step_results[i]);
    pixels_sent++;
    if (!quiet && $urandom_range(0, 11) == 0) begin
      gap = $urandom_range(1, 16);
      in_pix_if.valid <= 1'b0;
      pix_offered = 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [gb3_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gb3_pkg::CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    cfg_offered = 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      gb3_pkg::CFG_WIDTH:    width_reg = data;
      gb3_pkg::CFG_HEIGHT:   height_reg = data;
      gb3_pkg::CFG_CHANNELS: chans_reg = data[gb3_pkg::CH_CNT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain_block();
    if (pix_offered) begin
      in_pix_if.valid <= 1'b0;
      pix_offered = 1'b0;
    end
    if (cfg_offered) begin
      cfg_if.valid <= 1'b0;
      cfg_offered = 1'b0;
    end
    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_pix(input logic [gb3_pkg::PIX_W-1:0] px);
    dir_steps.push_back('{STEP_PIXEL, gb3_pkg::CFG_WIDTH, '0, px, 1'b0, '0});
  endtask

  task automatic add_pix_zero(input logic [gb3_pkg::PIX_W-1:0] px, input int col,
                              input int row);
    dir_steps.push_back('{STEP_PIXEL, gb3_pkg::CFG_WIDTH, '0, px, 1'b1,
                          '{gb3_pkg::COORD_W'(col), gb3_pkg::COORD_W'(row), '0, 1'b1}});
  endtask

  task automatic add_cfg(input logic [gb3_pkg::CFG_IDX_W-1:0] idx,
                         input logic [gb3_pkg::CFG_DATA_W-1:0] data);
    dir_steps.push_back('{STEP_CFG, idx, data, '0, 1'b0, '0});
  endtask

  always @(posedge clk) begin
    blur_res_t got, want;
    if (rst_n && out_pix_if.valid && out_pix_if.ready) begin
      got = '{out_pix_if.out_col, out_pix_if.out_row,
              {out_pix_if.chan3_out, out_pix_if.chan2_out,
               out_pix_if.chan1_out, out_pix_if.chan0_out},
              out_pix_if.last_of_run};
      results_seen++;
      if (results_due.size() == 0) begin
        err_cnt++;
        $display("%0t ns: expected no result, actual col %0d row %0d ch %h last %b",
                 $time, got.col, got.row, got.ch, got.last);
      end else begin
        want = results_due.pop_front();
        if (got !== want) begin
          err_cnt++;
          $display("%0t ns: expected %0d,%0d ch %h last %b, actual %0d,%0d ch %h last %b",
                   $time, want.col, want.row, want.ch, want.last,
                   got.col, got.row, got.ch, got.last);
        end
      end
    end
  end

  initial begin : sink_pacing
    int gap;
    out_pix_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !long_hold_done) begin
        long_hold_done = 1'b1;
        out_pix_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_pix_if.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        gap = $urandom_range(1, 16);
        out_pix_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
        out_pix_if.ready <= 1'b1;
      end else begin
        out_pix_if.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #(WATCHDOG_NS);
    $display("%0t ns: timeout with %0d results outstanding", $time, results_due.size());
    $display("gaussian_blur_3x3 regression: fail");
    $finish;
  end

  initial begin : stimulus
    int i, w_cfg, h_cfg, rand_items;
    rst_n <= 1'b0;
    in_pix_if.valid    <= 1'b0;
    in_pix_if.chan0_in <= '0;
    in_pix_if.chan1_in <= '0;
    in_pix_if.chan2_in <= '0;
    in_pix_if.chan3_in <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= gb3_pkg::CFG_WIDTH;
    cfg_if.data  <= '0;
    for (i = 0; i < LINE_DEPTH; i++) begin
      line_upper[i] = '0;
      line_middle[i] = '0;
    end
    for (i = 0; i < 6; i++) win[i] = '0;
    col_cnt = 0;
    row_cnt = 0;
    width_reg = gb3_pkg::CFG_DATA_W'(gb3_pkg::WIDTH_RST);
    height_reg = gb3_pkg::CFG_DATA_W'(gb3_pkg::HEIGHT_RST);
    chans_reg = CHANS_RST;

    add_pix_zero(32'hFFFF_FFFF, 0, 0);
    add_pix_zero(32'h0000_0000, 1, 0);
    add_pix_zero(32'h00FF_00FF, 2, 0);
    add_pix_zero(32'hFF00_FF00, 3, 0);
    add_cfg(gb3_pkg::CFG_WIDTH, 12'd3);
    add_pix_zero(32'h3CC3_5AA5, 4, 0);
    for (i = 0; i < 6; i++) add_pix(32'hFFFF_FFFF);
    add_cfg(gb3_pkg::CFG_HEIGHT, 12'd2);
    add_cfg(gb3_pkg::CFG_CHANNELS, 12'd7);
    add_pix(32'h80FF_0001);
    add_pix(32'h7F00_FFFE);
    add_pix(32'hFFFF_FFFF);
    add_cfg(gb3_pkg::CFG_CHANNELS, 12'd0);
    add_cfg(gb3_pkg::CFG_WIDTH, 12'd0);
    add_cfg(gb3_pkg::CFG_HEIGHT, 12'd0);
    add_cfg(CFG_SPARE, 12'hFFF);
    add_pix_zero(32'hFFFF_FFFF, 0, 0);
    add_pix_zero(32'hA5A5_A5A5, 0, 0);
    add_cfg(gb3_pkg::CFG_WIDTH, 12'd3);
    add_cfg(gb3_pkg::CFG_HEIGHT, 12'd3);
    add_cfg(gb3_pkg::CFG_CHANNELS, 12'hFF9);
    for (i = 0; i < 9; i++) add_pix(i[0] ? 32'h0000_0000 : 32'hFFFF_FFFF);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_steps[k]) begin
      if (dir_steps[k].kind == STEP_CFG) begin
        if (k > 0 && dir_steps[k-1].kind == STEP_PIXEL) drain_block();
        write_reg(dir_steps[k].idx, dir_steps[k].data);
      end else begin
        send_pixel(dir_steps[k].px, dir_steps[k].typed, dir_steps[k].res);
      end
    end

    // long row with a long output stall to back up the input
    drain_block();
    write_reg(gb3_pkg::CFG_WIDTH, gb3_pkg::CFG_DATA_W'(LONG_ROW));
    write_reg(gb3_pkg::CFG_HEIGHT, 12'd1);
    write_reg(gb3_pkg::CFG_CHANNELS, gb3_pkg::CFG_DATA_W'($urandom_range(0, 7)));
    frame_setups++;
    long_hold_req = 1'b1;
    for (i = 0; i < LONG_ROW; i++) send_pixel($urandom(), 1'b0, '0);

    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      w_cfg = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
      h_cfg = $urandom_range(0, 8);
      drain_block();
      write_reg(gb3_pkg::CFG_WIDTH, gb3_pkg::CFG_DATA_W'(w_cfg));
      write_reg(gb3_pkg::CFG_HEIGHT, gb3_pkg::CFG_DATA_W'(h_cfg));
      write_reg(gb3_pkg::CFG_CHANNELS, {9'($urandom()), 3'($urandom_range(0, 7))});
      if ($urandom_range(0, 7) == 0) write_reg(CFG_SPARE, gb3_pkg::CFG_DATA_W'($urandom()));
      frame_setups++;
      if (w_cfg == 0) w_cfg = 1;
      if (h_cfg == 0) h_cfg = 1;
      for (i = 0; i < w_cfg * h_cfg; i++) begin
        quiet = (rand_items >= RAND_ITEMS - QUIET_ITEMS);
        send_pixel($urandom(), 1'b0, '0);
        rand_items++;
      end
    end

    drain_block();
    $display("covered %0d pixels over %0d frame setups, %0d results checked",
             pixels_sent, frame_setups, results_seen);
    $display("included tiny frames, a mid-frame shrink, and a %0d-cycle output stall",
             LONG_HOLD);
    if (err_cnt == 0) begin
      $display("gaussian_blur_3x3 regression: pass");
    end else begin
      $display("gaussian_blur_3x3 regression: fail");
    end
    $finish;
  end

endmodule
